/* rtl/mscs_pkg.sv */
// package for the marching-squares case stream unit
// holds sizes, register indexes and the shared configuration and write types
// no dependencies
package mscs_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 3;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(32);
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(32);

  typedef struct packed {
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic             data;
  } lb_wr_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/mscs_cfg_regs.sv */
// configuration registers of the marching-squares case stream unit
// apb-style write and read port for grid_width and grid_height
// depends on mscs_pkg
module mscs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mscs_pkg::ADDR_W-1:0]   paddr,
  input  logic [mscs_pkg::DATA_W-1:0]   pwdata,
  output logic [mscs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mscs_pkg::cfg_t                cfg_o
);
  import mscs_pkg::*;

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (idx)
        REG_GRID_WIDTH:  width_d  = pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: height_d = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_WIDTH_RST;
      height_q <= GRID_HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_WIDTH:  prdata = DATA_W'(width_q);
      REG_GRID_HEIGHT: prdata = DATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.grid_width  = width_q;
  assign cfg_o.grid_height = height_q;

endmodule

/* rtl/mscs_line_buffer.sv */
// line buffer of sign flags, one per column of the previous row
// synchronous memory with registered read and write-to-read forwarding
// depends on mscs_pkg
module mscs_line_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [mscs_pkg::COL_W-1:0] rd_addr_i,
  output logic                       rd_data_o,
  input  mscs_pkg::lb_wr_t           wr_i
);
  import mscs_pkg::*;

  logic mem [MAX_WIDTH];
  logic mem_rd_q;
  logic fwd_q, fwd_d;
  logic fwd_data_q;

  assign fwd_d = wr_i.en & (wr_i.addr == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_addr_i];
      fwd_data_q <= wr_i.data;
    end
  end

  // same-edge write and read of one column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= fwd_d;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

/* rtl/marching_squares_case_stream_unit.sv */
// Marching-squares case stream unit: takes one Q16.16 signed-distance sample per transaction
// in raster order and returns one 4-bit case code per node (bit 0 upper-left, bit 1 upper,
// bit 2 left, bit 3 the node itself negative) with frame_end on the last node of the grid.
// A new sample can be taken every clock cycle while the output is not stalled; each sample passes
// through stage one (line-buffer read), then case build and write-back into the output register.
// The line buffer needs no clearing after reset.
// Depends on mscs_pkg, mscs_cfg_regs and mscs_line_buffer.
module marching_squares_case_stream_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mscs_pkg::ADDR_W-1:0] paddr,
  input  logic [mscs_pkg::DATA_W-1:0] pwdata,
  output logic [mscs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          sample_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [3:0]                  case_code_o,
  output logic                        frame_end_o
);
  import mscs_pkg::*;

  cfg_t             cfg;
  lb_wr_t           lb_wr;
  logic             lb_rd_data;
  logic [CFG_W-1:0] w_eff, h_eff;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_col, last_row;

  logic             s1_valid_q, s1_valid_d;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_self_q, s1_col0_q, s1_row0_q, s1_last_q;

  logic             left_q, ul_q;
  logic             out_valid_q, out_valid_d;
  logic [3:0]       case_q;
  logic             frame_end_q;

  logic             out_free, s1_adv, in_acc;
  logic             self_b, left_b, up_b, ul_b;

  mscs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mscs_line_buffer u_lb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rd_data),
    .wr_i      (lb_wr)
  );

  assign w_eff = clamp_size(cfg.grid_width, CFG_W'(MAX_WIDTH));
  assign h_eff = clamp_size(cfg.grid_height, CFG_W'(MAX_HEIGHT));

  // handshake
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign s1_adv      = s1_valid_q & out_free;
  assign in_stall_o  = s1_valid_q & ~out_free;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_acc | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  // raster position
  assign last_col = ({1'b0, col_q} + CFG_W'(1)) >= w_eff;
  assign last_row = ({1'b0, row_q} + CFG_W'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // case build
  assign self_b = s1_self_q;
  assign left_b = s1_col0_q ? self_b : left_q;
  assign up_b   = s1_row0_q ? self_b : lb_rd_data;
  assign ul_b   = s1_row0_q ? left_b : (s1_col0_q ? up_b : ul_q);

  assign lb_wr.en   = s1_adv;
  assign lb_wr.addr = s1_col_q;
  assign lb_wr.data = s1_self_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= 1'b0;
      ul_q        <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        left_q <= self_b;
        ul_q   <= lb_rd_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= col_q;
      s1_self_q <= sample_value_i[31];
      s1_col0_q <= (col_q == '0);
      s1_row0_q <= (row_q == '0);
      s1_last_q <= last_col & last_row;
    end
    if (s1_adv) begin
      case_q      <= {self_b, left_b, up_b, ul_b};
      frame_end_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign case_code_o = case_q;
  assign frame_end_o = frame_end_q;

  // checks
  a_acc_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted transaction missing from stage one");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q))
    else $error("stage one lost a held transaction");

  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced transaction missing from output register");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free stage");

endmodule
